// ===== rtl/core/rc6_pkg.sv =====
// Shared types, constants and word functions of the RC6-32/20 block cipher.
// No dependencies; rc6_ksched, rc6_core and rc6_block_cipher_top import this package.
`default_nettype none

package rc6_pkg;

  localparam int Rounds      = 20;
  localparam int MaxKeyWords = 8;
  localparam int NumRk       = 2 * Rounds + 4;
  localparam int RkAw        = $clog2(NumRk);
  localparam int StepW       = $clog2(Rounds + 2);
  localparam int KeyIdxW     = (MaxKeyWords > 1) ? $clog2(MaxKeyWords) : 1;
  localparam int KsSteps     = 3 * ((NumRk > MaxKeyWords) ? NumRk : MaxKeyWords);
  localparam int KsCntW      = $clog2(KsSteps);
  localparam int KwcW        = 4;
  localparam int NumKeyParts = 4;
  localparam int CfgAw       = 6;

  localparam logic [31:0] P32 = 32'hB7E15163;
  localparam logic [31:0] Q32 = 32'h9E3779B9;

  typedef enum logic [2:0] {
    RegKeyPart0     = 3'd0,
    RegKeyPart1     = 3'd1,
    RegKeyPart2     = 3'd2,
    RegKeyPart3     = 3'd3,
    RegKeyWordCount = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic        mode;
    logic [31:0] word_a;
    logic [31:0] word_b;
    logic [31:0] word_c;
    logic [31:0] word_d;
  } blk_in_t;

  typedef struct packed {
    logic [31:0] out_a;
    logic [31:0] out_b;
    logic [31:0] out_c;
    logic [31:0] out_d;
  } blk_out_t;

  typedef struct packed {
    logic            we;
    logic [RkAw-1:0] addr;
    logic [31:0]     data;
  } rk_wr_t;

  typedef logic [NumKeyParts-1:0][63:0] key_parts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} << n;
    return w[63:32];
  endfunction

  function automatic logic [31:0] rotr32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] w;
    w = {x, x} >> n;
    return w[31:0];
  endfunction

  // Low word of x * (2x + 1); the caller registers the product.
  function automatic logic [31:0] quad_prod(input logic [31:0] x);
    logic [31:0] odd;
    odd = {x[30:0], 1'b1};
    return x * odd;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/rc6_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rc6_ram #(
  parameter int Width = 32,
  parameter int Depth = 44
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/rc6_ksched.sv =====
// RC6 key schedule sequencer: mixing steps over the round key RAM, each an A phase (RAM write) then a B phase.
// Depends on rc6_pkg.
`default_nettype none

module rc6_ksched (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  rc6_pkg::key_parts_t      key_parts_i,
  input  logic [rc6_pkg::KwcW-1:0] kwc_i,
  input  logic [31:0]              rdata_i,
  output logic [rc6_pkg::RkAw-1:0] raddr_o,
  output rc6_pkg::rk_wr_t          wr_o,
  output logic                     done_o
);
  import rc6_pkg::*;

  logic                run_q;
  logic                ph_q;
  logic                done_q;
  logic [KsCntW-1:0]   s_q;
  logic [RkAw-1:0]     i_q, i_next;
  logic [KeyIdxW-1:0]  j_q, j_next;
  logic [KwcW-1:0]     c_q, c_clamp;
  logic [31:0]         a_q, b_q, pq_q;
  logic [31:0]         l_q [MaxKeyWords];
  logic [31:0]         rk_old, a_new, ab, b_new;
  logic                last_step;

  always_comb begin
    if (kwc_i == '0) begin
      c_clamp = KwcW'(1);
    end else if (kwc_i > KwcW'(MaxKeyWords)) begin
      c_clamp = KwcW'(MaxKeyWords);
    end else begin
      c_clamp = kwc_i;
    end
  end

  assign i_next    = (i_q == RkAw'(NumRk - 1)) ? '0 : i_q + RkAw'(1);
  assign j_next    = ((KwcW'(j_q) + KwcW'(1)) == c_q) ? '0 : j_q + KeyIdxW'(1);
  assign last_step = (s_q == KsCntW'(KsSteps - 1));

  // First pass takes the P/Q progression directly, later passes read back the RAM.
  assign rk_old = (s_q < KsCntW'(NumRk)) ? pq_q : rdata_i;
  assign a_new  = rotl32(rk_old + a_q + b_q, 5'd3);
  assign ab     = a_q + b_q;
  assign b_new  = rotl32(l_q[j_q] + ab, ab[4:0]);

  assign raddr_o = ph_q ? i_next : i_q;
  assign wr_o.we   = run_q && !ph_q;
  assign wr_o.addr = i_q;
  assign wr_o.data = a_new;
  assign done_o    = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      ph_q   <= 1'b0;
      done_q <= 1'b0;
      s_q    <= '0;
      i_q    <= '0;
      j_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        ph_q  <= 1'b0;
        s_q   <= '0;
        i_q   <= '0;
        j_q   <= '0;
      end else if (run_q) begin
        ph_q <= !ph_q;
        if (ph_q) begin
          s_q <= s_q + KsCntW'(1);
          i_q <= i_next;
          j_q <= j_next;
          if (last_step) begin
            run_q  <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      c_q  <= c_clamp;
      a_q  <= '0;
      b_q  <= '0;
      pq_q <= P32;
      for (int k = 0; k < MaxKeyWords; k++) begin
        l_q[k] <= key_parts_i[k / 2][(k % 2) * 32 +: 32];
      end
    end else if (run_q) begin
      if (!ph_q) begin
        a_q <= a_new;
      end else begin
        b_q      <= b_new;
        l_q[j_q] <= b_new;
        pq_q     <= pq_q + Q32;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rc6_core.sv =====
// RC6 block datapath: one shared 32x32 multiplier, Lo, Hi and Apply phases per round step,
// whitening steps at both ends. Depends on rc6_pkg; reads round keys from the RAM.
`default_nettype none

module rc6_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     go_i,
  input  rc6_pkg::blk_in_t         blk_i,
  input  logic [31:0]              rdata_i,
  output logic [rc6_pkg::RkAw-1:0] raddr_o,
  output rc6_pkg::blk_out_t        result_o,
  output logic                     valid_o
);
  import rc6_pkg::*;

  localparam logic [1:0] PhLo    = 2'd0;
  localparam logic [1:0] PhHi    = 2'd1;
  localparam logic [1:0] PhApply = 2'd2;

  localparam logic [StepW-1:0] LastStep = StepW'(Rounds + 1);

  logic             run_q, valid_q;
  logic [1:0]       ph_q;
  logic [StepW-1:0] step_q, key_idx;
  logic             mode_q;
  logic [31:0]      a_q, b_q, c_q, d_q;
  logic [31:0]      a_d, b_d, c_d, d_d;
  logic [31:0]      prod_q, t_q, lo_q, mix, xt, xu;

  assign key_idx = mode_q ? (LastStep - step_q) : step_q;
  assign raddr_o = RkAw'({key_idx, (ph_q == PhHi)});
  assign mix     = rotl32(prod_q, 5'd5);
  assign xt      = mode_q ? a_q : b_q;
  assign xu      = mode_q ? c_q : d_q;

  // Apply one step: lo_q holds the even round key, rdata_i the odd one.
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    if (!mode_q) begin
      if (step_q == '0) begin
        b_d = b_q + lo_q;
        d_d = d_q + rdata_i;
      end else if (step_q == LastStep) begin
        a_d = a_q + lo_q;
        c_d = c_q + rdata_i;
      end else begin
        a_d = b_q;
        b_d = rotl32(c_q ^ mix, t_q[4:0]) + rdata_i;
        c_d = d_q;
        d_d = rotl32(a_q ^ t_q, mix[4:0]) + lo_q;
      end
    end else begin
      if (step_q == '0) begin
        a_d = a_q - lo_q;
        c_d = c_q - rdata_i;
      end else if (step_q == LastStep) begin
        b_d = b_q - lo_q;
        d_d = d_q - rdata_i;
      end else begin
        a_d = rotr32(d_q - lo_q, mix[4:0]) ^ t_q;
        b_d = a_q;
        c_d = rotr32(b_q - rdata_i, t_q[4:0]) ^ mix;
        d_d = c_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      valid_q <= 1'b0;
      ph_q    <= PhLo;
      step_q  <= '0;
    end else begin
      valid_q <= 1'b0;
      if (go_i) begin
        run_q  <= 1'b1;
        ph_q   <= PhLo;
        step_q <= '0;
      end else if (run_q) begin
        unique case (ph_q)
          PhLo:    ph_q <= PhHi;
          PhHi:    ph_q <= PhApply;
          PhApply: begin
            ph_q <= PhLo;
            if (step_q == LastStep) begin
              run_q   <= 1'b0;
              valid_q <= 1'b1;
            end else begin
              step_q <= step_q + StepW'(1);
            end
          end
          default: ph_q <= PhLo;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go_i) begin
      mode_q <= blk_i.mode;
      a_q    <= blk_i.word_a;
      b_q    <= blk_i.word_b;
      c_q    <= blk_i.word_c;
      d_q    <= blk_i.word_d;
    end else if (run_q) begin
      unique case (ph_q)
        PhLo: begin
          prod_q <= quad_prod(xt);
        end
        PhHi: begin
          lo_q   <= rdata_i;
          t_q    <= mix;
          prod_q <= quad_prod(xu);
        end
        PhApply: begin
          a_q <= a_d;
          b_q <= b_d;
          c_q <= c_d;
          d_q <= d_d;
        end
        default: ;
      endcase
    end
  end

  assign result_o.out_a = a_q;
  assign result_o.out_b = b_q;
  assign result_o.out_c = c_q;
  assign result_o.out_d = d_q;
  assign valid_o        = valid_q;

endmodule

`default_nettype wire

// ===== rtl/core/rc6_block_cipher_top.sv =====
// RC6-32/20 top: key registers, sequencer, round key RAM, key schedule and datapath.
// Each block runs in Lo, Hi and Apply round-step phases around the shared multiplier and
// single RAM read port; busy drops only after the result beat, so a new block is accepted
// only once the previous result has been delivered. After reset or any key register write,
// the next block first expands keys.
// Reset clears the key registers (word count 4) and marks the round keys stale.
`default_nettype none

module rc6_block_cipher_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  rc6_pkg::blk_in_t          block_i,
  output rc6_pkg::blk_out_t         result_o,
  output logic                      result_valid_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [rc6_pkg::CfgAw-1:0] paddr,
  input  logic [63:0]               pwdata,
  output logic [63:0]               prdata,
  output logic                      pready
);
  import rc6_pkg::*;

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StKeys  = 2'd1;
  localparam logic [1:0] StGo    = 2'd2;
  localparam logic [1:0] StBlock = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             keys_ready_q;
  key_parts_t       key_parts_q;
  logic [KwcW-1:0]  kwc_q;
  blk_in_t          blk_q;
  logic             accept, cfg_wr, ks_start, ks_done, core_go;
  reg_idx_e         reg_idx;
  logic [RkAw-1:0]  ks_raddr, core_raddr, ram_raddr;
  logic [31:0]      ram_rdata;
  rk_wr_t           ks_wr;

  assign accept  = start && !busy;
  assign busy    = (state_q != StIdle);
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[CfgAw-1:3]);

  always_comb begin
    unique case (reg_idx)
      RegKeyPart0:     prdata = key_parts_q[0];
      RegKeyPart1:     prdata = key_parts_q[1];
      RegKeyPart2:     prdata = key_parts_q[2];
      RegKeyPart3:     prdata = key_parts_q[3];
      RegKeyWordCount: prdata = 64'(kwc_q);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_parts_q  <= '0;
      kwc_q        <= KwcW'(4);
      keys_ready_q <= 1'b0;
    end else begin
      if (ks_done) begin
        keys_ready_q <= 1'b1;
      end
      if (cfg_wr) begin
        unique case (reg_idx)
          RegKeyPart0: begin
            key_parts_q[0] <= pwdata;
            keys_ready_q   <= 1'b0;
          end
          RegKeyPart1: begin
            key_parts_q[1] <= pwdata;
            keys_ready_q   <= 1'b0;
          end
          RegKeyPart2: begin
            key_parts_q[2] <= pwdata;
            keys_ready_q   <= 1'b0;
          end
          RegKeyPart3: begin
            key_parts_q[3] <= pwdata;
            keys_ready_q   <= 1'b0;
          end
          RegKeyWordCount: begin
            kwc_q        <= pwdata[KwcW-1:0];
            keys_ready_q <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Sequencer: expand keys when stale, then run the block through the datapath.
  assign ks_start = accept && !keys_ready_q;
  assign core_go  = (state_q == StGo);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (accept) state_d = keys_ready_q ? StGo : StKeys;
      StKeys:  if (ks_done) state_d = StGo;
      StGo:    state_d = StBlock;
      StBlock: if (result_valid_o) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      blk_q <= block_i;
    end
  end

  assign ram_raddr = (state_q == StKeys) ? ks_raddr : core_raddr;

  rc6_ram #(
    .Width(32),
    .Depth(NumRk)
  ) u_rk_ram (
    .clk_i  (clk_i),
    .we_i   (ks_wr.we),
    .waddr_i(ks_wr.addr),
    .wdata_i(ks_wr.data),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  rc6_ksched u_ksched (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (ks_start),
    .key_parts_i(key_parts_q),
    .kwc_i      (kwc_q),
    .rdata_i    (ram_rdata),
    .raddr_o    (ks_raddr),
    .wr_o       (ks_wr),
    .done_o     (ks_done)
  );

  rc6_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (core_go),
    .blk_i   (blk_q),
    .rdata_i (ram_rdata),
    .raddr_o (core_raddr),
    .result_o(result_o),
    .valid_o (result_valid_o)
  );

  a_ks_done_in_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ks_done |-> (state_q == StKeys))
    else $error("key schedule finished outside key expansion");

  a_go_keys_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StGo) |-> keys_ready_q)
    else $error("block started with stale round keys");

  a_result_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q == StBlock))
    else $error("result beat without a block in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted block did not raise busy");

endmodule

`default_nettype wire
